// ===== rtl/skle_pkg.sv =====
// Shared types and command codes for the sorted key list engine.
package skle_pkg;

   localparam int KEY_W   = 32;
   localparam int CMD_W   = 4;
   localparam int COUNT_W = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_INS_HEAD   = 4'd0,
      CMD_INS_TAIL   = 4'd1,
      CMD_INS_SORTED = 4'd2,
      CMD_REM_HEAD   = 4'd3,
      CMD_REM_TAIL   = 4'd4,
      CMD_REM_KEY    = 4'd5,
      CMD_MEMBER     = 4'd6,
      CMD_ITER_START = 4'd7,
      CMD_ITER_NEXT  = 4'd8
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // capture the incoming item
      logic exec;   // carry out the captured command
   } ctl_type;

endpackage

// ===== rtl/skle_if.sv =====
// Handshake interfaces for the command and result channels.
interface skle_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  command;
   logic signed [31:0] key;

   modport source (output valid, output command, output key, input ready);
   modport sink   (input valid, input command, input key, output ready);
endinterface

interface skle_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic signed [31:0] key_out;
   logic        key_valid;
   logic [4:0]  count;
   logic        empty_res;

   modport source (output valid, output ok, output key_out, output key_valid,
                   output count, output empty_res, input ready);
   modport sink   (input valid, input ok, input key_out, input key_valid,
                   input count, input empty_res, output ready);
endinterface

// ===== rtl/skle_ctrl.sv =====
// Controller state machine: accept, execute, deliver.
module skle_ctrl
   import skle_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output ctl_type ctl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      ctl       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctl.exec = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/skle_dpath.sv =====
// Datapath: row of key cells with per-cell compare and shift, plus result registers.
module skle_dpath
   import skle_pkg::*;
#(
   parameter int CAPACITY = 16
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  ctl_type                   ctl,
   input  logic [CMD_W-1:0]          req_command,
   input  logic signed [KEY_W-1:0]   req_key,
   output logic                      rsp_ok,
   output logic signed [KEY_W-1:0]   rsp_key_out,
   output logic                      rsp_key_valid,
   output logic [COUNT_W-1:0]        rsp_count,
   output logic                      rsp_empty_res
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   logic [CMD_W-1:0]        cmd_ff;
   logic signed [KEY_W-1:0] key_ff;
   logic [KEY_W-1:0]        cells_ff [CAPACITY];
   logic [KEY_W-1:0]        cells_in [CAPACITY];
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           iter_pos_ff, iter_pos_in;
   logic                    iter_live_ff, iter_live_in;
   logic                    ok_ff, ok_in;
   logic [KEY_W-1:0]        key_out_ff, key_out_in;
   logic                    key_valid_ff, key_valid_in;

   logic [CAPACITY-1:0] occ, match, ge, pre_match, pre_ge;
   logic [CAPACITY-1:0] ins_after, rem_after;
   logic                found, full, empty, iter_more;
   logic                ins_cmd, do_ins, do_rem;
   logic [IW-1:0]       tail_idx, iter_idx;

   // Per-cell compares against the captured key.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         occ[i]   = CW'(i) < count_ff;
         match[i] = occ[i] && (cells_ff[i] == key_ff);
         ge[i]    = occ[i] && ($signed(cells_ff[i]) >= key_ff);
      end
      pre_match[0] = 1'b0;
      pre_ge[0]    = 1'b0;
      for (int i = 1; i < CAPACITY; i++) begin
         pre_match[i] = pre_match[i-1] | match[i-1];
         pre_ge[i]    = pre_ge[i-1] | ge[i-1];
      end
   end

   assign found     = pre_match[CAPACITY-1] | match[CAPACITY-1];
   assign full      = count_ff == CW'(CAPACITY);
   assign empty     = count_ff == '0;
   assign tail_idx  = IW'(count_ff - CW'(1));
   assign iter_idx  = iter_pos_ff[IW-1:0];
   assign iter_more = iter_live_ff && (iter_pos_ff < count_ff);

   // Command decode and next state.
   always_comb begin
      ins_cmd      = 1'b0;
      do_ins       = 1'b0;
      do_rem       = 1'b0;
      ins_after    = '0;
      rem_after    = '0;
      count_in     = count_ff;
      iter_pos_in  = iter_pos_ff;
      iter_live_in = iter_live_ff;
      ok_in        = 1'b0;
      key_out_in   = '0;
      key_valid_in = 1'b0;

      unique case (cmd_type'(cmd_ff)) inside
         CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_SORTED,
         CMD_REM_HEAD, CMD_REM_TAIL, CMD_REM_KEY: begin
            iter_live_in = 1'b0;
            iter_pos_in  = '0;
         end
         default: begin
         end
      endcase

      unique case (cmd_type'(cmd_ff))
         CMD_INS_HEAD: begin
            ins_cmd   = 1'b1;
            ins_after = '1;
         end
         CMD_INS_TAIL: begin
            ins_cmd   = 1'b1;
            ins_after = ~occ;
         end
         CMD_INS_SORTED: begin
            ins_cmd   = 1'b1;
            ins_after = pre_ge | ge | ~occ;
         end
         CMD_REM_HEAD: begin
            if (!empty) begin
               do_rem       = 1'b1;
               rem_after    = '1;
               key_out_in   = cells_ff[0];
               key_valid_in = 1'b1;
               ok_in        = 1'b1;
               count_in     = count_ff - CW'(1);
            end
         end
         CMD_REM_TAIL: begin
            if (!empty) begin
               key_out_in   = cells_ff[tail_idx];
               key_valid_in = 1'b1;
               ok_in        = 1'b1;
               count_in     = count_ff - CW'(1);
            end
         end
         CMD_REM_KEY: begin
            if (found) begin
               do_rem    = 1'b1;
               rem_after = pre_match | match;
               ok_in     = 1'b1;
               count_in  = count_ff - CW'(1);
            end
         end
         CMD_MEMBER: begin
            ok_in = found;
         end
         CMD_ITER_START: begin
            iter_pos_in  = '0;
            iter_live_in = 1'b1;
            ok_in        = !empty;
         end
         CMD_ITER_NEXT: begin
            if (iter_more) begin
               key_out_in   = cells_ff[iter_idx];
               key_valid_in = 1'b1;
               iter_pos_in  = iter_pos_ff + CW'(1);
               ok_in        = (iter_pos_ff + CW'(1)) < count_ff;
            end
         end
         default: begin
         end
      endcase

      if (ins_cmd && !full) begin
         do_ins   = 1'b1;
         ok_in    = 1'b1;
         count_in = count_ff + CW'(1);
      end
   end

   // Each cell takes the key, its lower neighbor, its upper neighbor, or holds.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_in[i] = cells_ff[i];
      end
      if (do_ins && ins_after[0]) begin
         cells_in[0] = key_ff;
      end
      for (int i = 1; i < CAPACITY; i++) begin
         if (do_ins && ins_after[i]) begin
            cells_in[i] = ins_after[i-1] ? cells_ff[i-1] : key_ff;
         end
      end
      for (int i = 0; i < CAPACITY - 1; i++) begin
         if (do_rem && rem_after[i]) begin
            cells_in[i] = cells_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         iter_pos_ff  <= '0;
         iter_live_ff <= 1'b0;
      end else if (ctl.exec) begin
         count_ff     <= count_in;
         iter_pos_ff  <= iter_pos_in;
         iter_live_ff <= iter_live_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= req_command;
         key_ff <= req_key;
      end
      if (ctl.exec) begin
         cells_ff     <= cells_in;
         ok_ff        <= ok_in;
         key_out_ff   <= key_out_in;
         key_valid_ff <= key_valid_in;
      end
   end

   assign rsp_ok        = ok_ff;
   assign rsp_key_out   = key_out_ff;
   assign rsp_key_valid = key_valid_ff;
   assign rsp_count     = COUNT_W'(count_ff);
   assign rsp_empty_res = count_ff == '0;

endmodule

// ===== rtl/sorted_key_list_engine.sv =====
// Top level of the sorted key list engine: controller, datapath and assertions.
//
// The block keeps a bounded list of up to CAPACITY signed 32-bit keys in a
// row of register cells, entry 0 being the head. Each command item inserts at
// the head, at the tail or in sorted position (before the first entry that is
// not smaller), removes the head, the tail or the first entry equal to a key,
// tests membership, or starts or steps the iterator; every command returns
// exactly one result item with the entry count after the command. Any insert
// or remove, successful or not, resets the iterator. An item is captured at
// the edge that accepts it. The next cycle carries it out, with every cell
// comparing its key and shifting toward its neighbor at once. The result is
// offered from the cycle after that until it is taken. Once it is taken the
// controller returns to idle, where it takes the next item, so the block
// does not take a new item before it is through with the last one. The
// command channel is ready only while the controller is idle, so it is never
// ready while a command is carried out or a result waits. There is no
// clearing pass after reset; cells beyond the entry count may be shifted but
// never reach a compare result or an output.
module sorted_key_list_engine
   import skle_pkg::*;
#(
   parameter int CAPACITY = 16
)
(
   input  logic       clock,
   input  logic       reset,
   skle_req_if.sink   req_ch,
   skle_rsp_if.source rsp_ch
);

   ctl_type ctl;

   // The controller sequences capture, execution and delivery of each item.
   skle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .ctl       (ctl)
   );

   // The datapath holds the cells, the count, the iterator and the result.
   skle_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .req_command   (req_ch.command),
      .req_key       (req_ch.key),
      .rsp_ok        (rsp_ch.ok),
      .rsp_key_out   (rsp_ch.key_out),
      .rsp_key_valid (rsp_ch.key_valid),
      .rsp_count     (rsp_ch.count),
      .rsp_empty_res (rsp_ch.empty_res)
   );

`ifndef SYNTHESIS
   // After an item is taken, no new item is taken and no result is shown
   // while the command is being carried out.
   assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready && !rsp_ch.valid)
      else $error("item accepted while previous command in flight");

   // A waiting result always blocks the command channel.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("command channel ready while result pending");

   // Once a result is taken the block is ready for the next item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready |=> req_ch.ready && !rsp_ch.valid)
      else $error("block not ready after result delivered");

   // Without a key the key field reads zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.key_valid |-> rsp_ch.key_out == '0)
      else $error("key_out nonzero without key_valid");
`endif

endmodule
